>>> src/dsw_pkg.sv
`timescale 1ns / 1ps
// dsw_pkg: shared types, register indexes and the seven-segment table
// for the debounced stopwatch digit. No dependencies.
package dsw_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD    = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd1875;
  localparam logic [CFG_W-1:0] BEAT_RST     = 16'd54000;

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic               display_write;
    logic [DIGIT_W-1:0] digit;
    logic               running;
    logic               locked_out;
  } result_t;

  // active low, bit0 = A ... bit6 = G
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'h0:    s = 7'h40;
      4'h1:    s = 7'h79;
      4'h2:    s = 7'h24;
      4'h3:    s = 7'h30;
      4'h4:    s = 7'h19;
      4'h5:    s = 7'h12;
      4'h6:    s = 7'h02;
      4'h7:    s = 7'h78;
      4'h8:    s = 7'h00;
      4'h9:    s = 7'h10;
      4'ha:    s = 7'h08;
      4'hb:    s = 7'h03;
      4'hc:    s = 7'h46;
      4'hd:    s = 7'h21;
      4'he:    s = 7'h06;
      4'hf:    s = 7'h0e;
      default: s = 7'h7f;
    endcase
    return s;
  endfunction

endpackage

>>> src/dsw_core.sv
`timescale 1ns / 1ps
// dsw_core: debounce, start/stop control, prescaler and digit counter.
// Produces the result of the current tick combinationally. Uses dsw_pkg.
module dsw_core #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DIGIT_BITS  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       level_i,
  input  logic [dsw_pkg::CFG_W-1:0]  debounce_ticks_i,
  input  logic [dsw_pkg::CFG_W-1:0]  beat_period_i,
  output dsw_pkg::result_t           result_o
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > dsw_pkg::CFG_W) ? COUNT_WIDTH : dsw_pkg::CFG_W;

  logic                   held_q, held_d;
  logic                   lock_q, lock_d;
  logic [COUNT_WIDTH-1:0] lcnt_q, lcnt_d;
  logic                   prev_q;
  logic [COUNT_WIDTH-1:0] pcnt_q, pcnt_d;
  logic [DIGIT_BITS-1:0]  digit_q, digit_d;

  logic                   edge_ok, press_ev, release_ev, acc;
  logic [COUNT_WIDTH-1:0] lcnt_inc, pcnt_base, pcnt_inc;
  logic [DIGIT_BITS-1:0]  digit_base;
  logic [dsw_pkg::DIGIT_W-1:0] digit_lo;

  always_comb begin
    edge_ok    = (level_i != prev_q) && !lock_q;
    press_ev   = edge_ok && !level_i && !held_q;
    release_ev = edge_ok && level_i && held_q;
    acc        = press_ev || release_ev;

    held_d = held_q;
    if (press_ev) begin
      held_d = 1'b1;
    end else if (release_ev) begin
      held_d = 1'b0;
    end

    lcnt_inc = lcnt_q + COUNT_WIDTH'(1);
    lock_d   = lock_q;
    lcnt_d   = lcnt_q;
    if (acc) begin
      lock_d = 1'b1;
      lcnt_d = '0;
    end else if (lock_q) begin
      if (CMP_W'(lcnt_inc) >= CMP_W'(debounce_ticks_i)) begin
        lock_d = 1'b0;
        lcnt_d = '0;
      end else begin
        lcnt_d = lcnt_inc;
      end
    end

    pcnt_base  = press_ev ? '0 : pcnt_q;
    digit_base = press_ev ? '0 : digit_q;
    pcnt_inc   = pcnt_base + COUNT_WIDTH'(1);
    pcnt_d     = pcnt_base;
    digit_d    = digit_base;
    if (held_d && !acc) begin
      if (CMP_W'(pcnt_inc) >= CMP_W'(beat_period_i)) begin
        pcnt_d  = '0;
        digit_d = digit_base + DIGIT_BITS'(1);
      end else begin
        pcnt_d = pcnt_inc;
      end
    end

    // shown digit always equals the digit after the current tick
    digit_lo               = dsw_pkg::DIGIT_W'(digit_d);
    result_o.segments      = dsw_pkg::seg_of(digit_lo);
    result_o.display_write = (digit_d != digit_q);
    result_o.digit         = digit_lo;
    result_o.running       = held_d;
    result_o.locked_out    = lock_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      lock_q  <= 1'b1;
      lcnt_q  <= '0;
      prev_q  <= 1'b1;
      pcnt_q  <= '0;
      digit_q <= '0;
    end else if (step_i) begin
      held_q  <= held_d;
      lock_q  <= lock_d;
      lcnt_q  <= lcnt_d;
      prev_q  <= level_i;
      pcnt_q  <= pcnt_d;
      digit_q <= digit_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lock_q |-> lcnt_q == '0)
    else $error("lockout count not cleared while unlocked");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(held_q) && $stable(digit_q) && $stable(lock_q))
    else $error("state moved without a transaction");

  a_press_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && press_ev |=> held_q && lock_q && digit_q == '0 && pcnt_q == '0)
    else $error("press did not restart the stopwatch");
`endif

endmodule

>>> src/debounced_stopwatch_digit.sv
`timescale 1ns / 1ps
// debounced_stopwatch_digit: top level with configuration registers and
// the result register. Uses dsw_pkg and dsw_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, button_level_i): one transaction
//   per timebase tick carrying the sampled, active-low button pin.
//   Output channel (out_valid_o/out_ready_i): one result transaction per
//   input transaction: segment pattern, display write flag, digit, running
//   and lockout status after that tick.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 debounce ticks, 1 beat period) at the clock edge; write only when idle.
//   out_valid_o rises in the cycle after input acceptance. Throughput is one
//   transaction per cycle when the receiver does not stall, set by the single
//   result register: a new tick is taken in the same cycle the held result
//   is taken. When the receiver stalls, the result is held and in_ready_o
//   drops until it is taken. Reset clears the result register, restores the
//   default register values and puts the button in its lockout period.
module debounced_stopwatch_digit #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DIGIT_BITS  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              button_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dsw_pkg::SEG_W-1:0]         segments_o,
  output logic                              display_write_o,
  output logic [dsw_pkg::DIGIT_W-1:0]       digit_o,
  output logic                              running_o,
  output logic                              locked_out_o,
  input  logic                              cfg_we_i,
  input  logic [dsw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dsw_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [dsw_pkg::CFG_W-1:0] debounce_q, beat_q;
  logic                      out_valid_q;
  dsw_pkg::result_t          res_d, res_q;
  logic                      accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= dsw_pkg::DEBOUNCE_RST;
      beat_q     <= dsw_pkg::BEAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsw_pkg::REG_DEBOUNCE_TICKS: debounce_q <= cfg_data_i;
        dsw_pkg::REG_BEAT_PERIOD:    beat_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsw_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DIGIT_BITS  (DIGIT_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .level_i          (button_level_i),
    .debounce_ticks_i (debounce_q),
    .beat_period_i    (beat_q),
    .result_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segments_o      = res_q.segments;
  assign display_write_o = res_q.display_write;
  assign digit_o         = res_q.digit;
  assign running_o       = res_q.running;
  assign locked_out_o    = res_q.locked_out;

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_empty_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q))
    else $error("stalled result changed or dropped");
`endif

endmodule

>>> verif/debounced_stopwatch_digit_checker.sv
`timescale 1ns / 1ps
// debounced_stopwatch_digit_checker: watches the tick, result and register ports,
// predicts every result of the stopwatch digit and compares it. Uses dsw_pkg.
module debounced_stopwatch_digit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          button_level_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [dsw_pkg::SEG_W-1:0]     segments_i,
  input  logic                          display_write_i,
  input  logic [dsw_pkg::DIGIT_W-1:0]   digit_i,
  input  logic                          running_i,
  input  logic                          locked_out_i,
  input  logic                          cfg_we_i,
  input  logic [dsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dsw_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fails_o,
  output int                            pending_o,
  output int                            ticks_o,
  output int                            starts_o,
  output int                            stops_o,
  output int                            wraps_o
);

  // active-low patterns, digit 0 in the low seven bits
  localparam logic [16*dsw_pkg::SEG_W-1:0] SEG_ROM = {
    7'h0e, 7'h06, 7'h21, 7'h46, 7'h03, 7'h08, 7'h10, 7'h00,
    7'h78, 7'h02, 7'h12, 7'h19, 7'h30, 7'h24, 7'h79, 7'h40
  };

  logic [dsw_pkg::CFG_W-1:0]   deb_ticks;
  logic [dsw_pkg::CFG_W-1:0]   beat_ticks;
  logic                        held;
  logic                        lock_on;
  logic [15:0]                 lock_cnt;
  logic                        last_level;
  logic [15:0]                 presc;
  logic [dsw_pkg::DIGIT_W-1:0] beat_digit;
  logic [dsw_pkg::DIGIT_W-1:0] shown;
  dsw_pkg::result_t            due_results[$];
  int                          n_fail;
  int                          n_results;
  int                          n_ticks;
  int                          n_starts;
  int                          n_stops;
  int                          n_wraps;

  function automatic dsw_pkg::result_t tick_stopwatch(input logic lvl);
    dsw_pkg::result_t r;
    logic             took;
    took = 1'b0;
    if (lvl != last_level && !lock_on) begin
      if (!lvl && !held) begin
        held       = 1'b1;
        beat_digit = '0;
        presc      = '0;
        took       = 1'b1;
        n_starts++;
      end else if (lvl && held) begin
        held = 1'b0;
        took = 1'b1;
        n_stops++;
      end
    end
    last_level = lvl;
    if (took) begin
      lock_on  = 1'b1;
      lock_cnt = '0;
    end else if (lock_on) begin
      lock_cnt = lock_cnt + 16'd1;
      if (lock_cnt >= deb_ticks) begin
        lock_on  = 1'b0;
        lock_cnt = '0;
      end
    end
    if (held && !took) begin
      presc = presc + 16'd1;
      if (presc >= beat_ticks) begin
        presc = '0;
        if (beat_digit == 4'hf) n_wraps++;
        beat_digit = beat_digit + dsw_pkg::DIGIT_W'(1);
      end
    end
    r.segments      = SEG_ROM[beat_digit*dsw_pkg::SEG_W +: dsw_pkg::SEG_W];
    r.display_write = (beat_digit != shown);
    r.digit         = beat_digit;
    r.running       = held;
    r.locked_out    = lock_on;
    shown           = beat_digit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dsw_pkg::result_t got;
    dsw_pkg::result_t want;
    if (!rst_ni) begin
      deb_ticks  = dsw_pkg::DEBOUNCE_RST;
      beat_ticks = dsw_pkg::BEAT_RST;
      held       = 1'b0;
      lock_on    = 1'b1;
      lock_cnt   = '0;
      last_level = 1'b1;
      presc      = '0;
      beat_digit = '0;
      shown      = '0;
      due_results.delete();
      n_fail     = 0;
      n_results  = 0;
      n_ticks    = 0;
      n_starts   = 0;
      n_stops    = 0;
      n_wraps    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == dsw_pkg::REG_DEBOUNCE_TICKS) begin
          deb_ticks = cfg_data_i;
        end else if (cfg_idx_i == dsw_pkg::REG_BEAT_PERIOD) begin
          beat_ticks = cfg_data_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = {segments_i, display_write_i, digit_i, running_i, locked_out_i};
        if (due_results.size() == 0) begin
          if (n_fail < 10) begin
            $display("result %0d arrived with no tick pending: seg=%h wr=%b dig=%0d run=%b lock=%b",
                     n_results, got.segments, got.display_write, got.digit, got.running,
                     got.locked_out);
          end
          n_fail++;
        end else begin
          want = due_results.pop_front();
          if (got.segments !== want.segments || got.display_write !== want.display_write ||
              got.digit !== want.digit || got.running !== want.running ||
              got.locked_out !== want.locked_out) begin
            if (n_fail < 10) begin
              $display("result %0d mismatch: exp seg=%h wr=%b dig=%0d run=%b lock=%b",
                       n_results, want.segments, want.display_write, want.digit,
                       want.running, want.locked_out);
              $display("                      got seg=%h wr=%b dig=%0d run=%b lock=%b",
                       got.segments, got.display_write, got.digit, got.running,
                       got.locked_out);
            end
            n_fail++;
          end
        end
        n_results++;
      end
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(tick_stopwatch(button_level_i));
        n_ticks++;
      end
    end
    fails_o   <= n_fail;
    pending_o <= due_results.size();
    ticks_o   <= n_ticks;
    starts_o  <= n_starts;
    stops_o   <= n_stops;
    wraps_o   <= n_wraps;
  end

endmodule

>>> verif/debounced_stopwatch_digit_tb.sv
`timescale 1ns / 1ps
// debounced_stopwatch_digit_tb: clock, reset, button tick stimulus, timing register
// writes and the verdict. Uses dsw_pkg, debounced_stopwatch_digit and its checker.
module debounced_stopwatch_digit_tb;

  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD  = 48;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          button_level;
  logic                          out_valid;
  logic                          out_ready;
  logic [dsw_pkg::SEG_W-1:0]     segments;
  logic                          display_write;
  logic [dsw_pkg::DIGIT_W-1:0]   digit;
  logic                          running;
  logic                          locked_out;
  logic                          cfg_we;
  logic [dsw_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [dsw_pkg::CFG_W-1:0]     cfg_data;

  int fails;
  int pending;
  int ticks;
  int starts;
  int stops;
  int wraps;

  bit tx_gaps_on;
  bit rx_stalls_on;
  bit long_stall_req;
  int n_items;
  int n_settings;
  int n_stalls;
  int n_pauses;
  int idle_cycles;

  debounced_stopwatch_digit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .button_level_i  (button_level),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .segments_o      (segments),
    .display_write_o (display_write),
    .digit_o         (digit),
    .running_o       (running),
    .locked_out_o    (locked_out),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  debounced_stopwatch_digit_checker digit_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .button_level_i  (button_level),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .segments_i      (segments),
    .display_write_i (display_write),
    .digit_i         (digit),
    .running_i       (running),
    .locked_out_i    (locked_out),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fails_o         (fails),
    .pending_o       (pending),
    .ticks_o         (ticks),
    .starts_o        (starts),
    .stops_o         (stops),
    .wraps_o         (wraps)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: short random stalls, or one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("debounced_stopwatch_digit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic push_level(input logic lvl);
    if (tx_gaps_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= lvl;
    do @(posedge clk); while (!in_ready);
    n_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_timing(input logic [dsw_pkg::CFG_W-1:0] deb,
                            input logic [dsw_pkg::CFG_W-1:0] beat);
    cfg_we   <= 1'b1;
    cfg_idx  <= dsw_pkg::REG_DEBOUNCE_TICKS;
    cfg_data <= deb;
    @(posedge clk);
    cfg_idx  <= dsw_pkg::REG_BEAT_PERIOD;
    cfg_data <= beat;
    @(posedge clk);
    cfg_we   <= 1'b0;
    n_settings++;
  endtask

  // presses and releases with optional contact bounce, plus glitches and noise
  task automatic gen_phase(input int quota, input logic [dsw_pkg::CFG_W-1:0] deb,
                           input logic [dsw_pkg::CFG_W-1:0] beat, input bit with_stall,
                           input bit with_pause);
    int   stop_at;
    int   span;
    logic want;
    bit   stalled;
    bit   paused;
    stop_at = n_items + quota;
    want    = 1'b0;
    stalled = 1'b0;
    paused  = 1'b0;
    while (n_items < stop_at) begin
      if (with_stall && !stalled && n_items > stop_at - quota / 2) begin
        long_stall_req = 1'b1;
        stalled        = 1'b1;
        n_stalls++;
      end
      if (with_pause && !paused && n_items > stop_at - quota / 3) begin
        settle();
        paused = 1'b1;
        n_pauses++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              push_level(want);
              push_level(!want);
            end
          end
          span = int'(deb) + 2 * int'(beat) + 6;
          if ($urandom_range(0, 7) == 0) span = int'(deb) + 17 * int'(beat) + 4;
          if (span > 120) span = 120;
          if (span > stop_at - n_items) span = stop_at - n_items;
          if (span < 1) span = 1;
          repeat ($urandom_range(1, span)) push_level(want);
          want = !want;
        end
        7, 8: begin
          repeat ($urandom_range(1, 8)) push_level(1'($urandom_range(0, 1)));
        end
        default: begin
          push_level(want);
          push_level(!want);
        end
      endcase
    end
  endtask

  initial begin
    logic [dsw_pkg::CFG_W-1:0] deb;
    logic [dsw_pkg::CFG_W-1:0] beat;
    int                        p;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    button_level   <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_idx        <= dsw_pkg::REG_DEBOUNCE_TICKS;
    cfg_data       <= '0;
    tx_gaps_on     = 1'b0;
    rx_stalls_on   = 1'b0;
    long_stall_req = 1'b0;
    n_items        = 0;
    n_settings     = 0;
    n_stalls       = 0;
    n_pauses       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default timing: start-up lockout swallows presses
    push_level(1'b0);
    push_level(1'b1);
    push_level(1'b0);
    push_level(1'b1);
    settle();

    // shortest timing: press, release lost in lockout, press while held, digit
    // wraps, release, press lost in lockout, release while idle
    set_timing(16'd1, 16'd1);
    push_level(1'b1);
    push_level(1'b0);
    push_level(1'b1);
    repeat (17) push_level(1'b0);
    push_level(1'b1);
    push_level(1'b0);
    push_level(1'b1);
    settle();

    for (p = 0; p < 14; p++) begin
      tx_gaps_on   = (p % 4 != 2) && (p < 12);
      rx_stalls_on = (p % 4 != 1) && (p < 12);
      case (p)
        5: begin
          deb  = 16'hffff;
          beat = 16'hffff;
        end
        6: begin
          deb  = '0;
          beat = '0;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       deb = 16'd1;
            1:       deb = 16'd2;
            2:       deb = dsw_pkg::CFG_W'($urandom_range(3, 8));
            default: deb = dsw_pkg::CFG_W'($urandom_range(9, 24));
          endcase
          case ($urandom_range(0, 3))
            0:       beat = 16'd1;
            1:       beat = dsw_pkg::CFG_W'($urandom_range(2, 5));
            2:       beat = dsw_pkg::CFG_W'($urandom_range(6, 16));
            default: beat = dsw_pkg::CFG_W'($urandom_range(17, 60));
          endcase
        end
      endcase
      set_timing(deb, beat);
      gen_phase((p == 5) ? 40 : 145, deb, beat, p == 3, p == 8);
      settle();
    end

    repeat (4) @(posedge clk);
    $display("ran %0d button ticks under %0d timing settings: %0d starts, %0d stops, %0d wraps",
             ticks, n_settings, starts, stops, wraps);
    $display("%0d long result hold-offs, %0d drained pauses, %0d results outstanding",
             n_stalls, n_pauses, pending);
    if (fails == 0 && pending == 0) begin
      $display("debounced_stopwatch_digit_tb: PASS");
    end else begin
      $display("debounced_stopwatch_digit_tb: FAIL");
    end
    $finish;
  end

endmodule
